>>> sv/ppu_pkg.sv
// particle pool update: shared types and codes
// used by the core, the port checker and the testbench; no dependencies
`timescale 1ns / 1ps

package ppu_pkg;

    localparam logic [1:0] ACT_SPAWN = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] CFG_ANIME_ENABLE = 2'd0;
    localparam logic [1:0] CFG_ANIME_SPEED  = 2'd1;

    localparam logic [15:0] ANIME_SPEED_RESET = 16'd7680;
    localparam logic [15:0] ALPHA_ONE         = 16'd256;

    typedef struct packed {
        logic [1:0]         action;
        logic [30:0]        duration;
        logic [39:0]        appearance;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
        logic signed [31:0] acc_z;
    } cmd_t;

    typedef struct packed {
        logic               valid_res;
        logic               last;
        logic [15:0]        frame;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [15:0]        out_width;
        logic [15:0]        out_height;
        logic [15:0]        alpha;
    } result_t;

    // one slot of the pool as held in memory
    typedef struct packed {
        logic [15:0]      frame;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [2:0][31:0] acc;
        logic [31:0]      size;
        logic [15:0]      alpha;
        logic [31:0]      life;
    } slot_t;

endpackage

>>> sv/particle_pool_update_core.sv
// particle pool update: top level, slot sequencer over one slot memory
// depends on ppu_pkg and ppu_ram
`timescale 1ns / 1ps

// channel  | handshake                | payload
// ---------+--------------------------+------------------------------
// command  | start / busy             | cmd (ppu_pkg::cmd_t)
// result   | result_strobe, one cycle | result (ppu_pkg::result_t)
// config   | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// a spawn scans past the occupied slots up to the first free one
// a tick scans past each free slot; each slot that stays live goes through
// the scan, load, six multiply/add steps on the shared 32x32 multiplier, the life
// update, a 16-step square root, the frame update and the write back, while a
// slot that expires skips the square root and the frame update
// a readout first walks down from the top slot to find the last live slot, then
// scans up the pool and reads each live slot through the single memory port
// reset (async, active low) clears the live flags and control; no clearing pass
// the receiver cannot stall: each result beat is shown for exactly one cycle

module particle_pool_update_core #(
    parameter int POOL_SIZE = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  ppu_pkg::cmd_t    cmd,
    output logic             result_strobe,
    output ppu_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data
);

    localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SIZE - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DISPATCH, ST_SPAWN, ST_TADV, ST_TSCAN, ST_TLOAD, ST_TMUL,
        ST_TADD, ST_TLIFE, ST_TSQRT, ST_TFRAME, ST_TWRITE, ST_RFIND, ST_RSCAN,
        ST_RWAIT
    } state_t;

    state_t              state_reg;
    ppu_pkg::cmd_t       cmd_reg;
    logic [POOL_SIZE-1:0] live_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    last_idx_reg;
    logic                anime_enable_reg;
    logic [15:0]         anime_speed_reg;
    ppu_pkg::slot_t      slot_reg;
    logic [2:0]          step_reg;
    logic signed [63:0]  prod_reg;
    logic [30:0]         adv_reg;
    logic [31:0]         root_x_reg;
    logic [17:0]         rem_reg;
    logic [15:0]         root_reg;
    logic [3:0]          sqrt_cnt_reg;
    logic                result_strobe_reg;
    ppu_pkg::result_t    result_reg;

    ppu_pkg::slot_t      ram_rdata;
    ppu_pkg::slot_t      ram_wdata;
    logic                ram_we;

    // saturate a wide signed sum to 32 bits
    function automatic logic [31:0] sat32(input logic signed [47:0] v);
        logic [31:0] r;
        if (v > 48'sd2147483647)
        begin
            r = 32'h7fff_ffff;
        end
        else if (v < -48'sd2147483648)
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign busy          = (state_reg != ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign result_strobe = result_strobe_reg;
    assign result        = result_reg;

    // spawn record built straight from the held command
    ppu_pkg::slot_t spawn_slot;
    always_comb
    begin
        spawn_slot.frame  = {cmd_reg.appearance[39:32], 8'h00};
        spawn_slot.pos    = {cmd_reg.pos_z, cmd_reg.pos_y, cmd_reg.pos_x};
        spawn_slot.vel    = {cmd_reg.vel_z, cmd_reg.vel_y, cmd_reg.vel_x};
        spawn_slot.acc    = {cmd_reg.acc_z, cmd_reg.acc_y, cmd_reg.acc_x};
        spawn_slot.size   = cmd_reg.appearance[31:0];
        spawn_slot.alpha  = ppu_pkg::ALPHA_ONE;
        spawn_slot.life   = {1'b0, cmd_reg.duration};
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = slot_reg;
        if (state_reg == ST_SPAWN && !live_reg[idx_reg])
        begin
            ram_we    = 1'b1;
            ram_wdata = spawn_slot;
        end
        else if (state_reg == ST_TWRITE)
        begin
            ram_we = 1'b1;
        end
    end

    ppu_ram #(
        .WIDTH($bits(ppu_pkg::slot_t)),
        .DEPTH(POOL_SIZE)
    ) u_slot_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (idx_reg),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    // empty pool marker and the cycles that put out a result beat
    ppu_pkg::result_t    empty_beat;
    logic                read_empty;
    logic                beat_fire;

    always_comb
    begin
        empty_beat      = '0;
        empty_beat.last = 1'b1;
        read_empty      = (state_reg == ST_RFIND) && !live_reg[idx_reg] && (idx_reg == '0);
        beat_fire       = read_empty || (state_reg == ST_RWAIT);
    end

    // datapath helpers for the tick steps
    logic [1:0]          axis;
    logic signed [31:0]  mul_a;
    logic signed [31:0]  add_a;
    logic signed [47:0]  add_sum;
    logic signed [32:0]  life_diff;
    logic [31:0]         life_sat;
    logic [17:0]         rem_shift;
    logic [17:0]         trial;
    logic [31:0]         frame_sum;

    always_comb
    begin
        axis      = step_reg[2:1];
        mul_a     = step_reg[0] ? $signed(slot_reg.vel[axis]) : $signed(slot_reg.acc[axis]);
        add_a     = step_reg[0] ? $signed(slot_reg.pos[axis]) : $signed(slot_reg.vel[axis]);
        add_sum   = $signed({{16{add_a[31]}}, add_a}) + $signed(prod_reg[63:16]);
        life_diff = $signed({slot_reg.life[31], slot_reg.life})
                    - $signed({2'b00, cmd_reg.duration});
        life_sat  = sat32(48'(life_diff));
        rem_shift = {rem_reg[15:0], root_x_reg[31:30]};
        trial     = {root_reg, 2'b01};
        frame_sum = {16'h0000, slot_reg.frame} + {1'b0, adv_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            live_reg          <= '0;
            idx_reg           <= '0;
            last_idx_reg      <= '0;
            step_reg          <= '0;
            sqrt_cnt_reg      <= '0;
            anime_enable_reg  <= 1'b0;
            anime_speed_reg   <= ppu_pkg::ANIME_SPEED_RESET;
            result_strobe_reg <= 1'b0;
        end
        else
        begin
            result_strobe_reg <= beat_fire;

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == ppu_pkg::CFG_ANIME_ENABLE)
                begin
                    anime_enable_reg <= cfg_data[0];
                end
                else if (cfg_index == ppu_pkg::CFG_ANIME_SPEED)
                begin
                    anime_speed_reg <= cfg_data;
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= cmd;
                        state_reg <= ST_DISPATCH;
                    end
                end

                ST_DISPATCH:
                begin
                    idx_reg <= '0;
                    unique case (cmd_reg.action)
                        ppu_pkg::ACT_SPAWN: state_reg <= ST_SPAWN;
                        ppu_pkg::ACT_TICK:  state_reg <= ST_TADV;
                        ppu_pkg::ACT_READ:
                        begin
                            idx_reg   <= LAST_IDX;
                            state_reg <= ST_RFIND;
                        end
                        default:            state_reg <= ST_IDLE;
                    endcase
                end

                // first free slot takes the particle, a full pool drops it
                ST_SPAWN:
                begin
                    if (!live_reg[idx_reg])
                    begin
                        live_reg[idx_reg] <= 1'b1;
                        state_reg         <= ST_IDLE;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end

                // frame advance is the same for every slot of this tick
                ST_TADV:
                begin
                    adv_reg   <= 31'(({16'h0000, cmd_reg.duration} * {31'h0, anime_speed_reg}) >> 16);
                    state_reg <= ST_TSCAN;
                end

                ST_TSCAN:
                begin
                    if (live_reg[idx_reg])
                    begin
                        state_reg <= ST_TLOAD;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end

                ST_TLOAD:
                begin
                    slot_reg  <= ram_rdata;
                    step_reg  <= '0;
                    state_reg <= ST_TMUL;
                end

                // even steps: acc*t into vel, odd steps: vel*t into pos
                ST_TMUL:
                begin
                    prod_reg  <= mul_a * $signed({1'b0, cmd_reg.duration});
                    state_reg <= ST_TADD;
                end

                ST_TADD:
                begin
                    if (step_reg[0])
                    begin
                        slot_reg.pos[axis] <= sat32(add_sum);
                    end
                    else
                    begin
                        slot_reg.vel[axis] <= sat32(add_sum);
                    end
                    if (step_reg == 3'd5)
                    begin
                        state_reg <= ST_TLIFE;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 3'd1;
                        state_reg <= ST_TMUL;
                    end
                end

                ST_TLIFE:
                begin
                    slot_reg.life <= life_sat;
                    if (life_sat[31] || life_sat == 32'h0)
                    begin
                        // expired: slot freed, frame left as is
                        slot_reg.alpha    <= '0;
                        live_reg[idx_reg] <= 1'b0;
                        state_reg         <= ST_TWRITE;
                    end
                    else
                    begin
                        root_x_reg   <= life_sat;
                        rem_reg      <= '0;
                        root_reg     <= '0;
                        sqrt_cnt_reg <= 4'd15;
                        state_reg    <= ST_TSQRT;
                    end
                end

                // restoring square root, two radicand bits per step
                ST_TSQRT:
                begin
                    root_x_reg <= {root_x_reg[29:0], 2'b00};
                    if (rem_shift >= trial)
                    begin
                        rem_reg  <= rem_shift - trial;
                        root_reg <= {root_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_shift;
                        root_reg <= {root_reg[14:0], 1'b0};
                    end
                    if (sqrt_cnt_reg == 4'd0)
                    begin
                        slot_reg.alpha <= (rem_shift >= trial) ? {root_reg[14:0], 1'b1}
                                                               : {root_reg[14:0], 1'b0};
                        state_reg      <= ST_TFRAME;
                    end
                    else
                    begin
                        sqrt_cnt_reg <= sqrt_cnt_reg - 4'd1;
                    end
                end

                ST_TFRAME:
                begin
                    if (anime_enable_reg)
                    begin
                        slot_reg.frame <= (frame_sum > 32'd65535) ? 16'hffff : frame_sum[15:0];
                    end
                    state_reg <= ST_TWRITE;
                end

                ST_TWRITE:
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IDX_W'(1);
                        state_reg <= ST_TSCAN;
                    end
                end

                // walk down to find the slot that gets the last marker
                ST_RFIND:
                begin
                    if (live_reg[idx_reg])
                    begin
                        last_idx_reg <= idx_reg;
                        idx_reg      <= '0;
                        state_reg    <= ST_RSCAN;
                    end
                    else if (idx_reg == '0)
                    begin
                        result_reg <= empty_beat;
                        state_reg  <= ST_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg - IDX_W'(1);
                    end
                end

                ST_RSCAN:
                begin
                    if (live_reg[idx_reg])
                    begin
                        state_reg <= ST_RWAIT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end

                ST_RWAIT:
                begin
                    result_reg.valid_res <= 1'b1;
                    result_reg.last      <= (idx_reg == last_idx_reg);
                    result_reg.frame     <= ram_rdata.frame;
                    result_reg.out_x     <= ram_rdata.pos[0];
                    result_reg.out_y     <= ram_rdata.pos[1];
                    result_reg.out_z     <= ram_rdata.pos[2];
                    result_reg.out_width <= ram_rdata.size[31:16];
                    result_reg.out_height <= ram_rdata.size[15:0];
                    result_reg.alpha     <= ram_rdata.alpha;
                    if (idx_reg == last_idx_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IDX_W'(1);
                        state_reg <= ST_RSCAN;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sv/ppu_ram.sv
// particle pool update: generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ppu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                          wdata,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> sv/ppu_checker.sv
// particle pool update: port-level checker and its bind to the core
// depends on ppu_pkg
`timescale 1ns / 1ps

module ppu_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             result_strobe,
    input ppu_pkg::result_t result
);

    // an accepted command always makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // result beats only come out of work in progress
    a_strobe_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result beat without work in progress");

    // the empty pool marker is always the final beat
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.valid_res) |-> result.last)
        else $error("empty marker without last");

    // a readout run ends with its last beat
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last) |=> !result_strobe)
        else $error("beat directly after last");

endmodule

bind particle_pool_update_core ppu_checker u_ppu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_strobe(result_strobe),
    .result       (result)
);

>>> tb/sv/tb.sv
// particle pool update testbench: directed and random command beats with a
// self-contained pool predictor, checked against every result beat
// depends on ppu_pkg and particle_pool_update_core
`timescale 1ns / 1ps

module tb;

    localparam int POOL = 64;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    ppu_pkg::cmd_t    cmd = '0;
    logic    result_strobe;
    ppu_pkg::result_t result;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    particle_pool_update_core #(.POOL_SIZE(POOL)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .result_strobe(result_strobe), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // predicted pool contents
    logic               anim_on;
    logic [15:0]        anim_rate;
    logic               live [POOL];
    logic [15:0]        frm [POOL];
    logic signed [31:0] pos [POOL][3];
    logic signed [31:0] vel [POOL][3];
    logic signed [31:0] acc [POOL][3];
    logic [31:0]        sz [POOL];
    logic [15:0]        alp [POOL];
    logic signed [31:0] life [POOL];

    ppu_pkg::result_t pending_beats[$];
    int      errors = 0;
    int      idle_pct = 0;

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sh7FFFFFFF)
            return 32'sh7FFFFFFF;
        if (v < -64'sh80000000)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // product with time, floor of the shift
    function automatic logic signed [63:0] scale_by_dt(input logic signed [31:0] a,
                                                       input logic [30:0] t);
        logic signed [63:0] p;
        p = 64'(a) * $signed({33'd0, t});
        return p >>> 16;
    endfunction

    function automatic logic [31:0] int_sqrt(input logic [31:0] x);
        logic [31:0] r, b;
        r = 0;
        b = 32'h40000000;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic predict_pool(input ppu_pkg::cmd_t c);
        int lastslot;
        logic [63:0] adv, f;
        logic signed [63:0] lf;
        ppu_pkg::result_t r;
        lastslot = -1;
        case (c.action)
            ppu_pkg::ACT_SPAWN:
            begin
                for (int s = 0; s < POOL; s++)
                    if (!live[s])
                    begin
                        live[s] = 1'b1;
                        frm[s] = {c.appearance[39:32], 8'd0};
                        sz[s] = c.appearance[31:0];
                        pos[s][0] = c.pos_x; pos[s][1] = c.pos_y; pos[s][2] = c.pos_z;
                        vel[s][0] = c.vel_x; vel[s][1] = c.vel_y; vel[s][2] = c.vel_z;
                        acc[s][0] = c.acc_x; acc[s][1] = c.acc_y; acc[s][2] = c.acc_z;
                        alp[s] = ppu_pkg::ALPHA_ONE;
                        life[s] = {1'b0, c.duration};
                        break;
                    end
            end
            ppu_pkg::ACT_TICK:
            begin
                for (int s = 0; s < POOL; s++)
                begin
                    if (!live[s])
                        continue;
                    for (int k = 0; k < 3; k++)
                    begin
                        vel[s][k] = clip32(64'(vel[s][k]) + scale_by_dt(acc[s][k], c.duration));
                        pos[s][k] = clip32(64'(pos[s][k]) + scale_by_dt(vel[s][k], c.duration));
                    end
                    lf = 64'(life[s]) - $signed({33'd0, c.duration});
                    life[s] = clip32(lf);
                    if (life[s] <= 0)
                    begin
                        alp[s] = 0;
                        live[s] = 1'b0;
                    end
                    else
                        alp[s] = int_sqrt(life[s]) > 65535 ? 16'hFFFF
                                                           : 16'(int_sqrt(life[s]));
                end
                if (anim_on)
                begin
                    adv = (64'(c.duration) * 64'(anim_rate)) >> 16;
                    for (int s = 0; s < POOL; s++)
                        if (live[s])
                        begin
                            f = 64'(frm[s]) + adv;
                            frm[s] = f > 65535 ? 16'hFFFF : f[15:0];
                        end
                end
            end
            ppu_pkg::ACT_READ:
            begin
                for (int s = 0; s < POOL; s++)
                    if (live[s])
                        lastslot = s;
                if (lastslot < 0)
                begin
                    r = '0;
                    r.last = 1'b1;
                    pending_beats.push_back(r);
                end
                for (int s = 0; s < POOL; s++)
                    if (live[s])
                    begin
                        r.valid_res = 1'b1;
                        r.last = (s == lastslot);
                        r.frame = frm[s];
                        r.out_x = pos[s][0]; r.out_y = pos[s][1]; r.out_z = pos[s][2];
                        r.out_width = sz[s][31:16];
                        r.out_height = sz[s][15:0];
                        r.alpha = alp[s];
                        pending_beats.push_back(r);
                    end
            end
            default: ;
        endcase
    endtask

    // result checker, the receiver never stalls
    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (pending_beats.size() == 0)
            begin
                $display("%0t unexpected result beat: expected none, actual %h", $time, result);
                errors++;
            end
            else
            begin
                if (result !== pending_beats[0])
                begin
                    $display("%0t result mismatch: expected %h, actual %h",
                             $time, pending_beats[0], result);
                    errors++;
                end
                void'(pending_beats.pop_front());
            end
        end
    end

    // busy seen low at an edge with start high means the beat went in there
    task automatic send_cmd(input ppu_pkg::cmd_t c);
        while ($urandom_range(99) < idle_pct)
            @(posedge clk);
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_pool(c);
        start <= 1'b0;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == ppu_pkg::CFG_ANIME_ENABLE)
            anim_on = val[0];
        else if (idx == ppu_pkg::CFG_ANIME_SPEED)
            anim_rate = val;
    endtask

    // wait for all readout beats plus the longest tick sweep
    task automatic drain;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (40 * POOL)
            @(posedge clk);
    endtask

    function automatic ppu_pkg::cmd_t rand_cmd(input logic [1:0] act, input bit wide);
        ppu_pkg::cmd_t c;
        logic [383:0]  raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        c = raw[$bits(ppu_pkg::cmd_t)-1:0];
        c.action = act;
        if (!wide)
        begin
            // moderate values so particles live several ticks
            c.duration = act == ppu_pkg::ACT_TICK ? 31'($urandom_range(32'h18000))
                                                  : 31'($urandom_range(32'h80000));
            c.pos_x = $signed(32'($urandom_range(32'h200000))) - 32'sh100000;
            c.vel_x = $signed(32'($urandom_range(32'h40000))) - 32'sh20000;
            c.acc_y = $signed(32'($urandom_range(32'h40000))) - 32'sh20000;
        end
        return c;
    endfunction

    task automatic test_directed;
        ppu_pkg::cmd_t c;
        send_cmd(rand_cmd(ppu_pkg::ACT_READ, 0));   // empty pool marker
        c = rand_cmd(ppu_pkg::ACT_SPAWN, 1);
        c.duration = '0;                            // zero lifetime
        send_cmd(c);
        send_cmd(rand_cmd(ppu_pkg::ACT_READ, 0));
        send_cmd(rand_cmd(ppu_pkg::ACT_TICK, 0));   // frees it
        send_cmd(rand_cmd(ppu_pkg::ACT_READ, 0));
        c = '1;
        c.action = ppu_pkg::ACT_SPAWN;
        send_cmd(c);                                // all ones, max lifetime
        c = '0;
        c.action = ppu_pkg::ACT_SPAWN;
        c.duration = 31'd1;
        c.pos_x = 32'sh80000000; c.vel_y = 32'sh80000000; c.acc_z = 32'sh80000000;
        send_cmd(c);
        c.action = ppu_pkg::ACT_TICK;
        c.duration = '1;                            // saturating tick
        send_cmd(c);
        send_cmd(rand_cmd(ppu_pkg::ACT_READ, 0));
        c = rand_cmd(ACT_UNUSED, 1);                // unused code
        send_cmd(c);
        send_cmd(rand_cmd(ppu_pkg::ACT_READ, 0));
    endtask

    task automatic test_full_pool;
        for (int i = 0; i < POOL + 2; i++)
            send_cmd(rand_cmd(ppu_pkg::ACT_SPAWN, 0));
        send_cmd(rand_cmd(ppu_pkg::ACT_READ, 0));
        for (int i = 0; i < 6; i++)
            send_cmd(rand_cmd(ppu_pkg::ACT_TICK, 0));
        send_cmd(rand_cmd(ppu_pkg::ACT_READ, 0));
    endtask

    task automatic test_random(input int n);
        int p;
        for (int i = 0; i < n; i++)
        begin
            p = $urandom_range(99);
            if (p < 45)
                send_cmd(rand_cmd(ppu_pkg::ACT_SPAWN, p < 5));
            else if (p < 75)
                send_cmd(rand_cmd(ppu_pkg::ACT_TICK, p < 48));
            else if (p < 97)
                send_cmd(rand_cmd(ppu_pkg::ACT_READ, 0));
            else
                send_cmd(rand_cmd(ACT_UNUSED, 1));
        end
    endtask

    initial
    begin
        anim_on = 1'b0;
        anim_rate = ppu_pkg::ANIME_SPEED_RESET;
        for (int s = 0; s < POOL; s++)
            live[s] = 1'b0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 36;
        test_directed();
        drain();
        write_reg(ppu_pkg::CFG_ANIME_ENABLE, 16'd1);
        test_full_pool();
        test_random(45);
        drain();
        write_reg(ppu_pkg::CFG_ANIME_SPEED, 16'hFFFF);
        write_reg(CFG_UNUSED, 16'h1234);            // out-of-range index
        idle_pct = 47;
        test_random(45);
        drain();
        write_reg(ppu_pkg::CFG_ANIME_SPEED, 16'd0);
        write_reg(ppu_pkg::CFG_ANIME_ENABLE, 16'd0);
        idle_pct = 0;
        test_random(25);
        drain();
        write_reg(ppu_pkg::CFG_ANIME_ENABLE, 16'd1);
        write_reg(ppu_pkg::CFG_ANIME_SPEED, 16'd1);
        test_random(25);
        send_cmd(rand_cmd(ppu_pkg::ACT_READ, 0));
        drain();

        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
